[rtl/core/prd_pkg.sv]
// shared types and constants for the packet receive deframer
`default_nettype none

package prd_pkg;

   // event codes carried on the result channel
   localparam logic [1:0] EV_HEADER   = 2'd0;
   localparam logic [1:0] EV_PAYLOAD  = 2'd1;
   localparam logic [1:0] EV_GOOD     = 2'd2;
   localparam logic [1:0] EV_MISMATCH = 2'd3;

   // reply codes and reply address
   localparam logic [7:0] REPLY_HOST = 8'h5F;
   localparam logic [7:0] REPLY_ACK  = 8'h56;
   localparam logic [7:0] REPLY_ERR  = 8'h5A;
   localparam logic [7:0] REPLY_NONE = 8'h00;

   // one result item
   typedef struct packed {
      logic [1:0]  event_kind;
      logic [7:0]  host_id;
      logic [7:0]  command;
      logic [15:0] payload_len;
      logic [7:0]  data_byte;
      logic        packet_done;
      logic [7:0]  reply_command;
      logic [7:0]  reply_host;
      logic [15:0] sum_received;
      logic [15:0] sum_computed;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/core/prd_parse.sv]
// frame parser: header, payload and checksum state with next-result logic
`default_nettype none

module prd_parse (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            accept,
   input  wire logic [7:0]      rx_byte,
   output logic                 res_valid,
   output prd_pkg::rsp_type     res
);

   typedef enum logic [2:0] {
      PH_HOST   = 3'd0,
      PH_CMD    = 3'd1,
      PH_LEN_LO = 3'd2,
      PH_LEN_HI = 3'd3,
      PH_DATA   = 3'd4,
      PH_SUM_LO = 3'd5,
      PH_SUM_HI = 3'd6
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] byte_count_ff, byte_count_in;
   logic [7:0]  held_host_ff, held_host_in;
   logic [7:0]  held_command_ff, held_command_in;
   logic [15:0] held_length_ff, held_length_in;
   logic [15:0] running_sum_ff, running_sum_in;
   logic [7:0]  sum_low_ff, sum_low_in;

   logic [15:0] len_full;
   logic [15:0] count_next;
   logic [15:0] sum_next;
   logic [15:0] rx_sum;

   assign len_full   = {rx_byte, held_length_ff[7:0]};
   assign count_next = byte_count_ff + 16'd1;
   assign sum_next   = running_sum_ff + {8'd0, rx_byte};
   assign rx_sum     = {rx_byte, sum_low_ff};

   always_comb begin
      phase_in        = phase_ff;
      byte_count_in   = byte_count_ff;
      held_host_in    = held_host_ff;
      held_command_in = held_command_ff;
      held_length_in  = held_length_ff;
      running_sum_in  = running_sum_ff;
      sum_low_in      = sum_low_ff;

      res_valid         = 1'b0;
      res.event_kind    = prd_pkg::EV_HEADER;
      res.host_id       = held_host_ff;
      res.command       = held_command_ff;
      res.payload_len   = held_length_ff;
      res.data_byte     = 8'd0;
      res.packet_done   = 1'b0;
      res.reply_command = prd_pkg::REPLY_NONE;
      res.reply_host    = 8'd0;
      res.sum_received  = 16'd0;
      res.sum_computed  = 16'd0;

      case (phase_ff)
         PH_CMD: begin
            held_command_in = rx_byte;
            phase_in        = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            held_length_in = {8'd0, rx_byte};
            phase_in       = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            held_length_in  = len_full;
            byte_count_in   = 16'd0;
            running_sum_in  = 16'd0;
            res_valid       = 1'b1;
            res.payload_len = len_full;
            if (len_full == 16'd0) begin
               phase_in        = PH_HOST;
               res.packet_done = 1'b1;
            end else begin
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            running_sum_in = sum_next;
            byte_count_in  = count_next;
            if (count_next == held_length_ff) begin
               phase_in = PH_SUM_LO;
            end
            res_valid      = 1'b1;
            res.event_kind = prd_pkg::EV_PAYLOAD;
            res.data_byte  = rx_byte;
         end
         PH_SUM_LO: begin
            sum_low_in = rx_byte;
            phase_in   = PH_SUM_HI;
         end
         PH_SUM_HI: begin
            phase_in         = PH_HOST;
            res_valid        = 1'b1;
            res.packet_done  = 1'b1;
            res.reply_host   = prd_pkg::REPLY_HOST;
            res.sum_received = rx_sum;
            res.sum_computed = running_sum_ff;
            if (rx_sum == running_sum_ff) begin
               res.event_kind    = prd_pkg::EV_GOOD;
               res.reply_command = prd_pkg::REPLY_ACK;
            end else begin
               res.event_kind    = prd_pkg::EV_MISMATCH;
               res.reply_command = prd_pkg::REPLY_ERR;
            end
         end
         default: begin
            held_host_in = rx_byte;
            phase_in     = PH_CMD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HOST;
         byte_count_ff   <= 16'd0;
         held_host_ff    <= 8'd0;
         held_command_ff <= 8'd0;
         held_length_ff  <= 16'd0;
         running_sum_ff  <= 16'd0;
         sum_low_ff      <= 8'd0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         byte_count_ff   <= byte_count_in;
         held_host_ff    <= held_host_in;
         held_command_ff <= held_command_in;
         held_length_ff  <= held_length_in;
         running_sum_ff  <= running_sum_in;
         sum_low_ff      <= sum_low_in;
      end
   end

   // payload count stays below the header length while streaming
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (byte_count_ff < held_length_ff))
      else $error("payload count reached length inside data phase");

   // a finished packet always returns to header hunting
   assert property (@(posedge clock) disable iff (reset)
      (accept && res_valid && res.packet_done) |=> (phase_ff == PH_HOST))
      else $error("packet done without return to host phase");

   // a payload request never follows a zero length header
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (held_length_ff != 16'd0))
      else $error("data phase with zero length");

endmodule

`default_nettype wire

[rtl/core/prd_skid.sv]
// result register with one skid entry
`default_nettype none

module prd_skid (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire prd_pkg::rsp_type  push_data,
   output logic                   full,
   output logic                   out_valid,
   input  wire logic              out_stall,
   output prd_pkg::rsp_type       out_data
);

   logic             main_valid_ff, main_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   prd_pkg::rsp_type main_ff, main_in;
   prd_pkg::rsp_type skid_ff, skid_in;
   logic             main_free;

   assign main_free = !main_valid_ff || !out_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (main_free) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = push_data;
            main_valid_in = push;
         end
      end else if (push) begin
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   // the skid entry is only ever occupied behind a held result
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry occupied with empty result register");

   // no new result may arrive while the skid entry is occupied
   assert property (@(posedge clock) disable iff (reset)
      !(push && skid_valid_ff))
      else $error("result pushed into full buffer");

   // a held result stays presented until taken
   assert property (@(posedge clock) disable iff (reset)
      (main_valid_ff && out_stall) |=> main_valid_ff)
      else $error("stalled result dropped");

endmodule

`default_nettype wire

[rtl/core/packet_receive_deframer_core.sv]
// top level of the packet receive deframer
`default_nettype none

// Link packet deframer. One received byte is taken per request; a packet is
// host, command, 16-bit length (low byte first), the payload, then a 16-bit
// checksum (low byte first) that must equal the modulo 65536 sum of the
// payload bytes. Results are: header parsed (with packet_done set when the
// length is zero), each payload byte, and at the end packet good (ACK 0x56)
// or checksum mismatch (ERR 0x5A), both with reply host 0x5F. Header bytes
// one to three and the low checksum byte give no result. Throughput is one
// byte per clock while req_stall is low: the parser updates its state in
// the cycle a byte is taken, and the result is registered into the output
// register. A one-entry skid behind the output register absorbs a stalled
// result, so req_stall rises only after the result side held off two results.
module packet_receive_deframer_core (
   input  wire logic        clock,
   input  wire logic        reset,

   // byte request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,

   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_event_kind,
   output logic [7:0]       rsp_host_id,
   output logic [7:0]       rsp_command,
   output logic [15:0]      rsp_payload_len,
   output logic [7:0]       rsp_data_byte,
   output logic             rsp_packet_done,
   output logic [7:0]       rsp_reply_command,
   output logic [7:0]       rsp_reply_host,
   output logic [15:0]      rsp_sum_received,
   output logic [15:0]      rsp_sum_computed
);

   // request handshake
   logic             accept;
   logic             buf_full;

   // parser result for the byte in flight
   logic             res_valid;
   prd_pkg::rsp_type res;
   prd_pkg::rsp_type out_data;

   assign req_stall = buf_full;
   assign accept    = req_valid && !buf_full;

   // framing state and per-byte decision
   prd_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_rx_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   // output register plus skid entry
   prd_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && res_valid),
      .push_data (res),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_data)
   );

   // unpack the result onto its ports
   assign rsp_event_kind    = out_data.event_kind;
   assign rsp_host_id       = out_data.host_id;
   assign rsp_command       = out_data.command;
   assign rsp_payload_len   = out_data.payload_len;
   assign rsp_data_byte     = out_data.data_byte;
   assign rsp_packet_done   = out_data.packet_done;
   assign rsp_reply_command = out_data.reply_command;
   assign rsp_reply_host    = out_data.reply_host;
   assign rsp_sum_received  = out_data.sum_received;
   assign rsp_sum_computed  = out_data.sum_computed;

endmodule

`default_nettype wire

[verif/packet_receive_deframer_core_tb.sv]
// self-checking testbench for the packet receive deframer core
`timescale 1ns / 100ps

module packet_receive_deframer_core_tb;

   // parser phases of the link framing, one per byte position
   typedef enum logic [2:0] {
      PH_HOST   = 3'd0,
      PH_CMD    = 3'd1,
      PH_LEN_LO = 3'd2,
      PH_LEN_HI = 3'd3,
      PH_DATA   = 3'd4,
      PH_SUM_LO = 3'd5,
      PH_SUM_HI = 3'd6
   } frame_phase_type;

   // everything the deframer remembers between bytes
   typedef struct packed {
      frame_phase_type phase;
      logic [15:0]     count;
      logic [7:0]      host;
      logic [7:0]      cmd;
      logic [15:0]     len;
      logic [15:0]     sum;
      logic [7:0]      sum_lo;
   } frame_state_type;

   localparam int RANDOM_BYTES   = 1150;
   localparam int LONG_PAYLOAD   = 258;     // all 0xff, so the checksum wraps
   localparam int HOLDOFF_START  = 300;
   localparam int HOLDOFF_CYCLES = 150;
   localparam int QUIET_FIRST    = 900;
   localparam int QUIET_LAST     = 1400;
   localparam int TAIL_CYCLES    = 20;
   localparam int MAX_REPORTS    = 10;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_event_kind;
   logic [7:0]  rsp_host_id;
   logic [7:0]  rsp_command;
   logic [15:0] rsp_payload_len;
   logic [7:0]  rsp_data_byte;
   logic        rsp_packet_done;
   logic [7:0]  rsp_reply_command;
   logic [7:0]  rsp_reply_host;
   logic [15:0] rsp_sum_received;
   logic [15:0] rsp_sum_computed;

   // link bytes waiting to be offered, and results still owed by the block
   logic [7:0]       link_bytes[$];
   prd_pkg::rsp_type expected_events[$];

   frame_state_type  gen_state;      // tracks framing while the stimulus is built
   frame_state_type  parse_state;    // tracks framing of bytes the block has taken
   prd_pkg::rsp_type predicted;
   bit               predicted_valid;
   prd_pkg::rsp_type observed;
   prd_pkg::rsp_type wanted;

   int           cycle_count = 0;
   int           holdoff_left = 0;
   int           fail_count = 0;
   int           report_count = 0;

   wire quiet_stretch = (cycle_count >= QUIET_FIRST) && (cycle_count < QUIET_LAST);

   packet_receive_deframer_core DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_host_id       (rsp_host_id),
      .rsp_command       (rsp_command),
      .rsp_payload_len   (rsp_payload_len),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_packet_done   (rsp_packet_done),
      .rsp_reply_command (rsp_reply_command),
      .rsp_reply_host    (rsp_reply_host),
      .rsp_sum_received  (rsp_sum_received),
      .rsp_sum_computed  (rsp_sum_computed)
   );

   always #6 clock = ~clock;

   // advance the framing by one link byte; has_result tells whether a result is due
   task automatic deframe_byte(inout frame_state_type st, input logic [7:0] b,
                               output prd_pkg::rsp_type r, output bit has_result);
      logic [15:0] rx_sum;
      r = '0;
      has_result = 1'b0;
      case (st.phase)
         PH_CMD: begin
            st.cmd   = b;
            st.phase = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            st.len   = {8'h00, b};
            st.phase = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            st.len[15:8] = b;
            st.count     = '0;
            st.sum       = '0;
            has_result   = 1'b1;
            r.event_kind = prd_pkg::EV_HEADER;
            // an empty packet finishes at its header, no reply
            if (st.len == 16'd0) begin
               r.packet_done = 1'b1;
               st.phase      = PH_HOST;
            end else begin
               st.phase = PH_DATA;
            end
         end
         PH_DATA: begin
            st.sum       = st.sum + {8'h00, b};
            st.count     = st.count + 16'd1;
            if (st.count == st.len)
               st.phase = PH_SUM_LO;
            has_result   = 1'b1;
            r.event_kind = prd_pkg::EV_PAYLOAD;
            r.data_byte  = b;
         end
         PH_SUM_LO: begin
            st.sum_lo = b;
            st.phase  = PH_SUM_HI;
         end
         PH_SUM_HI: begin
            rx_sum          = {b, st.sum_lo};
            st.phase        = PH_HOST;
            has_result      = 1'b1;
            r.packet_done   = 1'b1;
            r.reply_host    = prd_pkg::REPLY_HOST;
            r.sum_received  = rx_sum;
            r.sum_computed  = st.sum;
            if (rx_sum == st.sum) begin
               r.event_kind    = prd_pkg::EV_GOOD;
               r.reply_command = prd_pkg::REPLY_ACK;
            end else begin
               r.event_kind    = prd_pkg::EV_MISMATCH;
               r.reply_command = prd_pkg::REPLY_ERR;
            end
         end
         default: begin
            // host byte, and any stray phase code falls back here
            st.host  = b;
            st.phase = PH_CMD;
         end
      endcase
      // header fields always reflect the state after this byte
      r.host_id     = st.host;
      r.command     = st.cmd;
      r.payload_len = st.len;
   endtask

   // queue a byte for the driver and keep the build-time framing in step
   task automatic push_byte(input logic [7:0] b);
      prd_pkg::rsp_type scratch;
      bit               scratch_valid;
      deframe_byte(gen_state, b, scratch, scratch_valid);
      link_bytes.push_back(b);
   endtask

   // stimulus, reset and end of run
   initial begin : stimulus
      int          rand_bytes;
      bit          long_done;
      logic [7:0]  b;
      logic [15:0] csum;
      gen_state   = '0;
      parse_state = '0;
      rand_bytes  = 0;
      long_done   = 1'b0;
      csum        = '0;

      // empty packet: header only, done with no reply
      push_byte(8'hFF); push_byte(8'h00); push_byte(8'h00); push_byte(8'h00);
      // one byte payload, right checksum
      push_byte(8'h00); push_byte(8'hFF); push_byte(8'h01); push_byte(8'h00);
      push_byte(8'hFF); push_byte(8'hFF); push_byte(8'h00);
      // two byte payload, checksum wrong in the low byte
      push_byte(8'hA5); push_byte(8'h5A); push_byte(8'h02); push_byte(8'h00);
      push_byte(8'h80); push_byte(8'h7F); push_byte(8'h00); push_byte(8'h00);
      // zero payload byte, checksum wrong only in the high byte
      push_byte(8'h5F); push_byte(8'h56); push_byte(8'h01); push_byte(8'h00);
      push_byte(8'h00); push_byte(8'h00); push_byte(8'h01);

      // mostly well-formed packets with random content, some corrupt checksums
      // and a little noise; one long packet whose checksum wraps
      while (rand_bytes < RANDOM_BYTES) begin
         if (!long_done && rand_bytes >= 500 && gen_state.phase == PH_HOST) begin
            push_byte(8'($urandom_range(0, 255)));
            push_byte(8'($urandom_range(0, 255)));
            push_byte(8'(LONG_PAYLOAD % 256));
            push_byte(8'(LONG_PAYLOAD / 256));
            repeat (LONG_PAYLOAD) push_byte(8'hFF);
            csum = gen_state.sum;
            push_byte(csum[7:0]);
            push_byte(csum[15:8]);
            rand_bytes = rand_bytes + LONG_PAYLOAD + 6;
            long_done  = 1'b1;
         end else begin
            if ($urandom_range(0, 99) < 6 && gen_state.phase != PH_LEN_LO
                && gen_state.phase != PH_LEN_HI) begin
               b = 8'($urandom_range(0, 255));    // noise byte
            end else begin
               case (gen_state.phase)
                  PH_LEN_LO: begin
                     case ($urandom_range(0, 19))
                        0, 1:    b = 8'h00;
                        2, 3, 4: b = 8'($urandom_range(9, 40));
                        default: b = 8'($urandom_range(1, 8));
                     endcase
                  end
                  PH_LEN_HI: b = 8'h00;
                  PH_DATA: begin
                     case ($urandom_range(0, 7))
                        0:       b = 8'h00;
                        1:       b = 8'hFF;
                        default: b = 8'($urandom_range(0, 255));
                     endcase
                  end
                  PH_SUM_LO: begin
                     csum = gen_state.sum;
                     if ($urandom_range(0, 99) < 15)
                        csum = csum ^ (16'h0001 << $urandom_range(0, 15));
                     b = csum[7:0];
                  end
                  PH_SUM_HI: b = csum[15:8];
                  default:   b = 8'($urandom_range(0, 255));
               endcase
            end
            push_byte(b);
            rand_bytes = rand_bytes + 1;
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // every byte taken, every result seen, then a short tail for strays
      while (link_bytes.size() != 0 || req_valid) @(posedge clock);
      while (expected_events.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("packet_receive_deframer_core_tb OK");
      else
         $display("packet_receive_deframer_core_tb NOT OK");
      $finish;
   end

   // run limit, far beyond the slowest correct run
   initial begin
      #2400000;
      $display("packet_receive_deframer_core_tb NOT OK");
      $finish;
   end

   // cycle count and the long result hold-off that backs the block up
   always @(posedge clock) begin
      if (reset) begin
         cycle_count  <= 0;
         holdoff_left <= 0;
      end else begin
         cycle_count <= cycle_count + 1;
         if (cycle_count == HOLDOFF_START)
            holdoff_left <= HOLDOFF_CYCLES;
         else if (holdoff_left != 0)
            holdoff_left <= holdoff_left - 1;
      end
   end

   // driver: predicts each accepted request, then offers the next byte or idles
   always @(posedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         req_rx_byte <= 8'h00;
      end else begin
         if (req_valid && !req_stall) begin
            deframe_byte(parse_state, req_rx_byte, predicted, predicted_valid);
            if (predicted_valid)
               expected_events.push_back(predicted);
         end
         // a stalled request stays exactly as it is
         if (!req_valid || !req_stall) begin
            if (link_bytes.size() != 0 && (quiet_stretch || $urandom_range(0, 99) >= 21)) begin
               req_valid   <= 1'b1;
               req_rx_byte <= link_bytes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each accepted result against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            observed.event_kind    = rsp_event_kind;
            observed.host_id       = rsp_host_id;
            observed.command       = rsp_command;
            observed.payload_len   = rsp_payload_len;
            observed.data_byte     = rsp_data_byte;
            observed.packet_done   = rsp_packet_done;
            observed.reply_command = rsp_reply_command;
            observed.reply_host    = rsp_reply_host;
            observed.sum_received  = rsp_sum_received;
            observed.sum_computed  = rsp_sum_computed;
            if (expected_events.size() == 0) begin
               fail_count = fail_count + 1;
               if (report_count < MAX_REPORTS) begin
                  report_count = report_count + 1;
                  $display("unexpected result kind %0d host %h cmd %h len %h data %h",
                           observed.event_kind, observed.host_id, observed.command,
                           observed.payload_len, observed.data_byte);
               end
            end else begin
               wanted = expected_events.pop_front();
               if (observed.event_kind    !== wanted.event_kind    ||
                   observed.host_id       !== wanted.host_id       ||
                   observed.command       !== wanted.command       ||
                   observed.payload_len   !== wanted.payload_len   ||
                   observed.data_byte     !== wanted.data_byte     ||
                   observed.packet_done   !== wanted.packet_done   ||
                   observed.reply_command !== wanted.reply_command ||
                   observed.reply_host    !== wanted.reply_host    ||
                   observed.sum_received  !== wanted.sum_received  ||
                   observed.sum_computed  !== wanted.sum_computed) begin
                  fail_count = fail_count + 1;
                  if (report_count < MAX_REPORTS) begin
                     report_count = report_count + 1;
                     $display("mismatch at %0t (kind host cmd len data done rcmd rhost srx scomp)",
                              $realtime);
                     $display("  expected %h %h %h %h %h %h %h %h %h %h",
                              wanted.event_kind, wanted.host_id, wanted.command,
                              wanted.payload_len, wanted.data_byte, wanted.packet_done,
                              wanted.reply_command, wanted.reply_host,
                              wanted.sum_received, wanted.sum_computed);
                     $display("  actual   %h %h %h %h %h %h %h %h %h %h",
                              observed.event_kind, observed.host_id, observed.command,
                              observed.payload_len, observed.data_byte, observed.packet_done,
                              observed.reply_command, observed.reply_host,
                              observed.sum_received, observed.sum_computed);
                  end
               end
            end
         end
         // random back-pressure, none in the quiet stretch, solid during the hold-off
         rsp_stall <= (holdoff_left != 0) ||
                      (!quiet_stretch && $urandom_range(0, 99) < 21);
      end
   end

endmodule

[filelist.f]
rtl/core/prd_pkg.sv
rtl/core/prd_parse.sv
rtl/core/prd_skid.sv
rtl/core/packet_receive_deframer_core.sv
verif/packet_receive_deframer_core_tb.sv
